[rtl/core/mdps_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// mdps_pkg
// Shared types, microword field positions and codes for the datapath step.
// ---------------------------------------------------------------------------
package mdps_pkg;

	// Default data memory size in words
	localparam int MDPS_MEM_WORDS = 16;

	// Depth of the queue between front and back
	localparam int QUEUE_DEPTH = 4;

	localparam int WORD_W = 32;
	localparam int MW_W   = 23;

	// Microword bit positions
	localparam int MW_SLL8  = 22;
	localparam int MW_SRA1  = 21;
	localparam int MW_F0    = 20;
	localparam int MW_F1    = 19;
	localparam int MW_ENA   = 18;
	localparam int MW_ENB   = 17;
	localparam int MW_INVA  = 16;
	localparam int MW_INC   = 15;
	localparam int MW_C_MAR = 14;
	localparam int MW_C_MDR = 13;
	localparam int MW_C_PC  = 12;
	localparam int MW_C_SP  = 11;
	localparam int MW_C_LV  = 10;
	localparam int MW_C_CPP = 9;
	localparam int MW_C_TOS = 8;
	localparam int MW_C_OPC = 7;
	localparam int MW_C_H   = 6;
	localparam int MW_WRITE = 5;
	localparam int MW_READ  = 4;
	localparam int MW_TOP_HI = 22;
	localparam int MW_TOP_LO = 15;

	// Item operation codes
	typedef enum logic [1:0] {
		OP_EXEC     = 2'd0,
		OP_LOAD_MEM = 2'd1,
		OP_LOAD_REG = 2'd2,
		OP_PEEK     = 2'd3
	} op_t;

	// Item class after decode
	typedef enum logic [2:0] {
		KIND_EXEC,
		KIND_FETCH,
		KIND_LOAD_MEM,
		KIND_LOAD_REG,
		KIND_PEEK
	} kind_t;

	// B bus source select
	localparam logic [3:0] BSEL_MDR  = 4'd0;
	localparam logic [3:0] BSEL_PC   = 4'd1;
	localparam logic [3:0] BSEL_MBRS = 4'd2;
	localparam logic [3:0] BSEL_MBRU = 4'd3;
	localparam logic [3:0] BSEL_SP   = 4'd4;
	localparam logic [3:0] BSEL_LV   = 4'd5;
	localparam logic [3:0] BSEL_CPP  = 4'd6;
	localparam logic [3:0] BSEL_TOS  = 4'd7;
	localparam logic [3:0] BSEL_OPC  = 4'd8;

	// ALU function codes {F0, F1}
	localparam logic [1:0] ALU_AND  = 2'b00;
	localparam logic [1:0] ALU_OR   = 2'b01;
	localparam logic [1:0] ALU_NOTB = 2'b10;
	localparam logic [1:0] ALU_ADD  = 2'b11;

	// Register preload targets
	localparam logic [3:0] TGT_MAR = 4'd0;
	localparam logic [3:0] TGT_MDR = 4'd1;
	localparam logic [3:0] TGT_PC  = 4'd2;
	localparam logic [3:0] TGT_MBR = 4'd3;
	localparam logic [3:0] TGT_SP  = 4'd4;
	localparam logic [3:0] TGT_LV  = 4'd5;
	localparam logic [3:0] TGT_CPP = 4'd6;
	localparam logic [3:0] TGT_TOS = 4'd7;
	localparam logic [3:0] TGT_OPC = 4'd8;
	localparam logic [3:0] TGT_H   = 4'd9;

	// Decoded item as it travels through the queue
	typedef struct packed {
		kind_t             kind;
		logic [MW_W-1:0]   micro_word;
		logic [3:0]        target;
		logic [WORD_W-1:0] load_data;
		logic              tgt_ok;
	} item_t;

	// Queue write side
	typedef struct packed {
		logic  valid;
		item_t item;
	} q_push_t;

	// Queue read side
	typedef struct packed {
		logic  valid;
		item_t item;
	} q_head_t;

endpackage
`default_nettype wire

[rtl/core/mdps_front.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// mdps_front
// Accepts input beats and classifies them into decoded queue entries.
// ---------------------------------------------------------------------------
module mdps_front
	import mdps_pkg::*;
#(
	parameter int MEM_WORDS = MDPS_MEM_WORDS
) (
	input  wire logic              item_valid,
	output logic                   item_ready,
	input  wire logic [1:0]        operation,
	input  wire logic [MW_W-1:0]   micro_word,
	input  wire logic [3:0]        target,
	input  wire logic [WORD_W-1:0] load_data,
	input  wire logic              q_full,
	input  wire logic              back_busy,
	output q_push_t                push
);

	logic [WORD_W-1:0] tgt_ext;
	kind_t             kind;

	// Hold off beats while the queue is full or memory is being cleared
	assign item_ready = !q_full && !back_busy;

	assign tgt_ext = {{(WORD_W-4){1'b0}}, target};

	// Classify the beat
	always_comb begin
		unique case (op_t'(operation))
			OP_EXEC: begin
				if (micro_word[MW_WRITE] && micro_word[MW_READ])
					kind = KIND_FETCH;
				else
					kind = KIND_EXEC;
			end
			OP_LOAD_MEM: kind = KIND_LOAD_MEM;
			OP_LOAD_REG: kind = KIND_LOAD_REG;
			OP_PEEK:     kind = KIND_PEEK;
			default:     kind = KIND_EXEC;
		endcase
	end

	// Build the queue entry
	always_comb begin
		push.valid           = item_valid && item_ready;
		push.item.kind       = kind;
		push.item.micro_word = micro_word;
		push.item.target     = target;
		push.item.load_data  = load_data;
		push.item.tgt_ok     = tgt_ext < WORD_W'(MEM_WORDS);
	end

endmodule
`default_nettype wire

[rtl/core/mdps_queue.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// mdps_queue
// Short FIFO of decoded items between the front and the back.
// ---------------------------------------------------------------------------
module mdps_queue
	import mdps_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire q_push_t push,
	output logic         full,
	output q_head_t      head,
	input  wire logic    pop
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	item_t            ent_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_pop;

	assign full       = cnt_q == CNT_W'(QUEUE_DEPTH);
	assign head.valid = cnt_q != '0;
	assign head.item  = ent_q[rd_ptr_q];
	assign do_pop     = pop && head.valid;

	// Store entries
	always_ff @(posedge clk) begin
		if (push.valid)
			ent_q[wr_ptr_q] <= push.item;
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push.valid) begin
				if (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1))
					wr_ptr_q <= '0;
				else
					wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				if (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1))
					rd_ptr_q <= '0;
				else
					rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push.valid && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (!push.valid && do_pop)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

[rtl/core/mdps_back.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// mdps_back
// Executes decoded items: register file, ALU, shifter, data memory and the
// result register.
// ---------------------------------------------------------------------------
module mdps_back
	import mdps_pkg::*;
#(
	parameter int MEM_WORDS = MDPS_MEM_WORDS
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire q_head_t      head,
	output logic              pop,
	output logic              busy,
	output logic              result_valid,
	input  wire logic         result_ready,
	output logic [WORD_W-1:0] h_value,
	output logic [WORD_W-1:0] mdr_value,
	output logic [WORD_W-1:0] mar_value,
	output logic              fetch_done,
	output logic [WORD_W-1:0] bus_b_value,
	output logic [WORD_W-1:0] shifter_value,
	output logic [WORD_W-1:0] peek_value
);

	localparam int AW = $clog2(MEM_WORDS);

	// Architectural registers
	logic [WORD_W-1:0] mar_q, mdr_q, pc_q, sp_q, lv_q, cpp_q, tos_q, opc_q, h_q;
	logic [7:0]        mbr_q;

	// Next values
	logic [WORD_W-1:0] mar_n, mdr_n, pc_n, sp_n, lv_n, cpp_n, tos_n, opc_n, h_n;
	logic [7:0]        mbr_n;

	// Memory and clear sweep
	logic [WORD_W-1:0] mem_q [MEM_WORDS];
	logic [WORD_W-1:0] rd_q;
	logic [AW-1:0]     clr_idx_q;
	logic              clr_busy_q;
	logic              rd_pend_q;

	// Result register
	logic              valid_s2;
	logic [WORD_W-1:0] h_s2, mdr_s2, mar_s2, busb_s2, shv_s2;
	logic              fetch_s2, mdr_rd_s2, peek_rd_s2;

	// Execute-cycle signals
	logic              take;
	logic [MW_W-1:0]   mw;
	logic [WORD_W-1:0] tgt_ext;
	logic [WORD_W-1:0] bus_b, a_in, b_in, alu_out, shv;
	logic [WORD_W-1:0] busb_o, shv_o;
	logic              fetch_o;
	logic              ex_we, ex_re, pk_re;
	logic [AW-1:0]     ex_addr;
	logic [WORD_W-1:0] ex_wdata;
	logic              mem_we, mem_re;
	logic [AW-1:0]     mem_waddr, mem_raddr;
	logic [WORD_W-1:0] mem_wdata;

	// Advance when the clear sweep is done, MDR is settled and the result
	// register is free
	assign take = head.valid && !clr_busy_q && !rd_pend_q && (!valid_s2 || result_ready);
	assign pop  = take;
	assign busy = clr_busy_q;

	assign mw      = head.item.micro_word;
	assign tgt_ext = {{(WORD_W-4){1'b0}}, head.item.target};

	// Drive the B bus
	always_comb begin
		unique case (mw[3:0])
			BSEL_MDR:  bus_b = mdr_q;
			BSEL_PC:   bus_b = pc_q;
			BSEL_MBRS: bus_b = {{(WORD_W-8){mbr_q[7]}}, mbr_q};
			BSEL_MBRU: bus_b = {{(WORD_W-8){1'b0}}, mbr_q};
			BSEL_SP:   bus_b = sp_q;
			BSEL_LV:   bus_b = lv_q;
			BSEL_CPP:  bus_b = cpp_q;
			BSEL_TOS:  bus_b = tos_q;
			BSEL_OPC:  bus_b = opc_q;
			default:   bus_b = '0;
		endcase
	end

	// ALU and shifter
	always_comb begin
		a_in = mw[MW_ENA] ? h_q : '0;
		if (mw[MW_INVA])
			a_in = ~a_in;
		b_in = mw[MW_ENB] ? bus_b : '0;
		unique case ({mw[MW_F0], mw[MW_F1]})
			ALU_AND:  alu_out = a_in & b_in;
			ALU_OR:   alu_out = a_in | b_in;
			ALU_NOTB: alu_out = ~b_in;
			ALU_ADD:  alu_out = a_in + b_in;
			default:  alu_out = '0;
		endcase
		alu_out = alu_out + {{(WORD_W-1){1'b0}}, mw[MW_INC]};
		if (mw[MW_SLL8])
			shv = {alu_out[WORD_W-9:0], 8'd0};
		else if (mw[MW_SRA1])
			shv = {alu_out[WORD_W-1], alu_out[WORD_W-1:1]};
		else
			shv = alu_out;
	end

	// Work out the register and memory effects of the head item
	always_comb begin
		mar_n = mar_q; mdr_n = mdr_q; pc_n = pc_q; sp_n = sp_q; lv_n = lv_q;
		cpp_n = cpp_q; tos_n = tos_q; opc_n = opc_q; h_n = h_q; mbr_n = mbr_q;
		busb_o   = '0;
		shv_o    = '0;
		fetch_o  = 1'b0;
		ex_we    = 1'b0;
		ex_re    = 1'b0;
		pk_re    = 1'b0;
		ex_addr  = tgt_ext[AW-1:0];
		ex_wdata = head.item.load_data;
		unique case (head.item.kind)
			KIND_EXEC: begin
				busb_o = bus_b;
				shv_o  = shv;
				if (mw[MW_C_MAR]) mar_n = shv;
				if (mw[MW_C_MDR]) mdr_n = shv;
				if (mw[MW_C_PC])  pc_n  = shv;
				if (mw[MW_C_SP])  sp_n  = shv;
				if (mw[MW_C_LV])  lv_n  = shv;
				if (mw[MW_C_CPP]) cpp_n = shv;
				if (mw[MW_C_TOS]) tos_n = shv;
				if (mw[MW_C_OPC]) opc_n = shv;
				if (mw[MW_C_H])   h_n   = shv;
				ex_addr  = mar_n[AW-1:0];
				ex_wdata = mdr_n;
				if (mar_n < WORD_W'(MEM_WORDS)) begin
					ex_we = mw[MW_WRITE];
					ex_re = mw[MW_READ];
				end
			end
			KIND_FETCH: begin
				mbr_n   = mw[MW_TOP_HI:MW_TOP_LO];
				h_n     = {{(WORD_W-8){1'b0}}, mw[MW_TOP_HI:MW_TOP_LO]};
				fetch_o = 1'b1;
			end
			KIND_LOAD_MEM: begin
				ex_we = head.item.tgt_ok;
			end
			KIND_LOAD_REG: begin
				unique case (head.item.target)
					TGT_MAR: mar_n = head.item.load_data;
					TGT_MDR: mdr_n = head.item.load_data;
					TGT_PC:  pc_n  = head.item.load_data;
					TGT_MBR: mbr_n = head.item.load_data[7:0];
					TGT_SP:  sp_n  = head.item.load_data;
					TGT_LV:  lv_n  = head.item.load_data;
					TGT_CPP: cpp_n = head.item.load_data;
					TGT_TOS: tos_n = head.item.load_data;
					TGT_OPC: opc_n = head.item.load_data;
					TGT_H:   h_n   = head.item.load_data;
					default: ;
				endcase
			end
			KIND_PEEK: begin
				pk_re = head.item.tgt_ok;
			end
			default: ;
		endcase
	end

	// Memory port select: clear sweep owns the write port until done
	always_comb begin
		mem_we    = clr_busy_q || (take && ex_we);
		mem_waddr = clr_busy_q ? clr_idx_q : ex_addr;
		mem_wdata = clr_busy_q ? '0 : ex_wdata;
		mem_re    = take && (ex_re || pk_re);
		mem_raddr = ex_addr;
	end

	// Data memory with registered read
	always_ff @(posedge clk) begin
		if (mem_we)
			mem_q[mem_waddr] <= mem_wdata;
		if (mem_re)
			rd_q <= mem_q[mem_raddr];
	end

	// Clear sweep after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clr_busy_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == AW'(MEM_WORDS - 1))
				clr_busy_q <= 1'b0;
		end
	end

	// Architectural registers; MDR takes read data in the cycle after a READ
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mar_q <= '0; mdr_q <= '0; pc_q <= '0; sp_q <= '0; lv_q <= '0;
			cpp_q <= '0; tos_q <= '0; opc_q <= '0; h_q <= '0; mbr_q <= '0;
			rd_pend_q <= 1'b0;
		end else begin
			rd_pend_q <= take && ex_re;
			if (rd_pend_q)
				mdr_q <= rd_q;
			if (take) begin
				mar_q <= mar_n; mdr_q <= mdr_n; pc_q <= pc_n; sp_q <= sp_n;
				lv_q <= lv_n; cpp_q <= cpp_n; tos_q <= tos_n; opc_q <= opc_n;
				h_q <= h_n; mbr_q <= mbr_n;
			end
		end
	end

	// Result valid: set on advance, drop when the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (take)
			valid_s2 <= 1'b1;
		else if (result_ready)
			valid_s2 <= 1'b0;
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (take) begin
			h_s2       <= h_n;
			mdr_s2     <= mdr_n;
			mar_s2     <= mar_n;
			busb_s2    <= busb_o;
			shv_s2     <= shv_o;
			fetch_s2   <= fetch_o;
			mdr_rd_s2  <= ex_re;
			peek_rd_s2 <= pk_re;
		end
	end

	assign result_valid  = valid_s2;
	assign h_value       = h_s2;
	assign mdr_value     = mdr_rd_s2 ? rd_q : mdr_s2;
	assign mar_value     = mar_s2;
	assign fetch_done    = fetch_s2;
	assign bus_b_value   = busb_s2;
	assign shifter_value = shv_s2;
	assign peek_value    = peek_rd_s2 ? rd_q : '0;

endmodule
`default_nettype wire

[rtl/core/microprogrammed_datapath_step.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// microprogrammed_datapath_step
// Stack-machine datapath executing one microinstruction, preload or peek
// per item, with a word data memory.
// ---------------------------------------------------------------------------
//  channel  handshake                  payload
//  item     item_valid / item_ready    operation, micro_word, target, load_data
//  result   result_valid / result_ready h_value, mdr_value, mar_value,
//                                       fetch_done, bus_b_value,
//                                       shifter_value, peek_value
//
//  One item per cycle unless a READ, the clear or a held result stalls. A
//  READ that hits memory holds the next item: the memory read port is
//  registered and MDR is reloaded in the next cycle. Result valid rises at
//  the edge the item leaves the queue, which a stall can delay after accept.
//  After reset the data memory is cleared word by word, item_ready low.
//  A 4-entry queue separates input and execution; a stalled result holds the
//  back part while the front keeps filling the queue.
// ---------------------------------------------------------------------------
module microprogrammed_datapath_step
	import mdps_pkg::*;
#(
	parameter int MEM_WORDS = MDPS_MEM_WORDS
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_ready,
	input  wire logic [1:0]        operation,
	input  wire logic [MW_W-1:0]   micro_word,
	input  wire logic [3:0]        target,
	input  wire logic [WORD_W-1:0] load_data,
	output logic                   result_valid,
	input  wire logic              result_ready,
	output logic [WORD_W-1:0]      h_value,
	output logic [WORD_W-1:0]      mdr_value,
	output logic [WORD_W-1:0]      mar_value,
	output logic                   fetch_done,
	output logic [WORD_W-1:0]      bus_b_value,
	output logic [WORD_W-1:0]      shifter_value,
	output logic [WORD_W-1:0]      peek_value
);

	q_push_t push;
	q_head_t head;
	logic    q_full;
	logic    pop;
	logic    back_busy;

	mdps_front #(
		.MEM_WORDS(MEM_WORDS)
	) u_front (
		.item_valid(item_valid),
		.item_ready(item_ready),
		.operation (operation),
		.micro_word(micro_word),
		.target    (target),
		.load_data (load_data),
		.q_full    (q_full),
		.back_busy (back_busy),
		.push      (push)
	);

	mdps_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.full  (q_full),
		.head  (head),
		.pop   (pop)
	);

	mdps_back #(
		.MEM_WORDS(MEM_WORDS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.pop          (pop),
		.busy         (back_busy),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.h_value      (h_value),
		.mdr_value    (mdr_value),
		.mar_value    (mar_value),
		.fetch_done   (fetch_done),
		.bus_b_value  (bus_b_value),
		.shifter_value(shifter_value),
		.peek_value   (peek_value)
	);

endmodule
`default_nettype wire
